@@ src/i2cm_pkg.sv @@
package i2cm_pkg;

  typedef enum logic [3:0] {
    PH_FREE     = 4'd0,
    PH_HELD     = 4'd1,
    PH_RST      = 4'd2,
    PH_STA_A    = 4'd3,
    PH_STA_B    = 4'd4,
    PH_STO_A    = 4'd5,
    PH_STO_B    = 4'd6,
    PH_STO_C    = 4'd7,
    PH_WR_LO    = 4'd8,
    PH_WR_HI    = 4'd9,
    PH_ACK_HI   = 4'd10,
    PH_ACK_POLL = 4'd11,
    PH_RD_LO    = 4'd12,
    PH_RD_HI    = 4'd13,
    PH_MA_LO    = 4'd14,
    PH_MA_HI    = 4'd15
  } phase_e;

  localparam logic [2:0] ACT_BUS_RESET = 3'd0;
  localparam logic [2:0] ACT_START     = 3'd1;
  localparam logic [2:0] ACT_STOP      = 3'd2;
  localparam logic [2:0] ACT_WRITE     = 3'd3;
  localparam logic [2:0] ACT_READ      = 3'd4;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_HALF_BIT    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACK_TIMEOUT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RESET_HOLD  = 2'd2;

  localparam logic [15:0] HALF_BIT_RST    = 16'd5;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
  localparam logic [15:0] RESET_HOLD_RST  = 16'd50;

  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } res_t;

  typedef struct packed {
    logic [15:0] half_bit_ticks;
    logic [7:0]  ack_timeout_ticks;
    logic [15:0] reset_hold_ticks;
  } cfg_t;

endpackage

@@ src/i2cm_cmd_if.sv @@
interface i2cm_cmd_if;
  logic            valid;
  logic            ready;
  i2cm_pkg::cmd_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/i2cm_res_if.sv @@
interface i2cm_res_if;
  logic            valid;
  logic            ready;
  i2cm_pkg::res_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/i2c_bit_level_master.sv @@
// Each accepted command item is one timer tick; its result item is registered and
// offered in the cycle after acceptance.
// Throughput is one item per cycle: the tick logic and the single result register
// accept a new item whenever the result register is empty or is being emptied.
// Reset leaves the bus free and the engine idle, clears the received byte and the
// ACK error, and loads the timing registers with 5, 250 and 50 ticks.
module i2c_bit_level_master #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  i2cm_cmd_if.sink                            cmd_i,
  i2cm_res_if.source                          res_o,
  input  logic                                cfg_we_i,
  input  logic [i2cm_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import i2cm_pkg::*;

  cfg_t cfg_q;
  res_t res_d;
  logic out_ready;
  logic step;

  assign cmd_i.ready = out_ready;
  assign step        = cmd_i.valid & out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit_ticks    <= HALF_BIT_RST;
      cfg_q.ack_timeout_ticks <= ACK_TIMEOUT_RST;
      cfg_q.reset_hold_ticks  <= RESET_HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_HALF_BIT:    cfg_q.half_bit_ticks    <= cfg_wdata_i;
        CFG_ACK_TIMEOUT: cfg_q.ack_timeout_ticks <= cfg_wdata_i[7:0];
        CFG_RESET_HOLD:  cfg_q.reset_hold_ticks  <= cfg_wdata_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  i2cm_seq #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cmd_i  (cmd_i.data),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  i2cm_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .data_i  (res_d),
    .ready_o (out_ready),
    .res_o   (res_o)
  );

endmodule

@@ src/i2cm_seq.sv @@
module i2cm_seq #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  i2cm_pkg::cmd_t cmd_i,
  input  i2cm_pkg::cfg_t cfg_i,
  output i2cm_pkg::res_t res_o
);
  import i2cm_pkg::*;

  localparam int unsigned LenW = ((TIMER_WIDTH > 17) ? TIMER_WIDTH : 17) + 1;

  phase_e                 phase_q, phase_d;
  logic [3:0]             bit_q, bit_d;
  logic [7:0]             shift_q, shift_d;
  logic [TIMER_WIDTH-1:0] timer_q, timer_d;
  logic [7:0]             wait_q, wait_d;
  logic                   fail_q, fail_d;
  logic                   choice_q, choice_d;
  logic [7:0]             rx_q, rx_d;

  logic [15:0]            half_eff, hold_eff;
  logic [TIMER_WIDTH-1:0] t_half, t_dbl, t_hold;
  logic                   idle, done;
  logic                   scl, sda, drive;

  function automatic logic [TIMER_WIDTH-1:0] sat_len(input logic [LenW-1:0] v);
    logic [TIMER_WIDTH-1:0] r;
    if (|v[LenW-1:TIMER_WIDTH]) begin
      r = '1;
    end else begin
      r = v[TIMER_WIDTH-1:0];
    end
    return r;
  endfunction

  assign half_eff = (cfg_i.half_bit_ticks == '0) ? 16'd1 : cfg_i.half_bit_ticks;
  assign hold_eff = (cfg_i.reset_hold_ticks == '0) ? 16'd1 : cfg_i.reset_hold_ticks;
  assign t_half   = sat_len(LenW'(half_eff) - LenW'(1));
  assign t_dbl    = sat_len((LenW'(half_eff) << 1) - LenW'(1));
  assign t_hold   = sat_len(LenW'(hold_eff) - LenW'(1));

  always_comb begin
    phase_d  = phase_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    timer_d  = timer_q;
    wait_d   = wait_q;
    fail_d   = fail_q;
    choice_d = choice_q;
    rx_d     = rx_q;
    done     = 1'b0;
    scl      = 1'b1;
    sda      = 1'b1;
    drive    = 1'b1;
    idle     = (phase_q == PH_FREE) || (phase_q == PH_HELD);

    if (idle && cmd_i.cmd_valid && (cmd_i.action <= ACT_READ)) begin
      idle = 1'b0;
      unique case (cmd_i.action)
        ACT_BUS_RESET: begin
          phase_d = PH_RST;
          timer_d = t_hold;
        end
        ACT_START: begin
          phase_d = PH_STA_A;
          timer_d = t_dbl;
        end
        ACT_STOP: begin
          phase_d = PH_STO_A;
          timer_d = t_dbl;
        end
        ACT_WRITE: begin
          shift_d = cmd_i.tx_byte;
          bit_d   = '0;
          fail_d  = 1'b0;
          phase_d = PH_WR_LO;
          timer_d = t_half;
        end
        default: begin
          shift_d  = '0;
          bit_d    = '0;
          choice_d = cmd_i.send_ack;
          phase_d  = PH_RD_LO;
          timer_d  = t_half;
        end
      endcase
    end

    unique case (phase_d)
      PH_FREE, PH_STA_A, PH_STO_C: begin
        scl = 1'b1; sda = 1'b1; drive = 1'b1;
      end
      PH_HELD, PH_RD_LO: begin
        scl = 1'b0; sda = 1'b1; drive = 1'b0;
      end
      PH_RST, PH_STO_A: begin
        scl = 1'b0; sda = 1'b0; drive = 1'b1;
      end
      PH_STA_B, PH_STO_B: begin
        scl = 1'b1; sda = 1'b0; drive = 1'b1;
      end
      PH_WR_LO: begin
        scl = 1'b0;
        if (bit_d >= BYTE_BITS) begin
          sda = 1'b1; drive = 1'b0;
        end else begin
          sda = shift_d[7]; drive = 1'b1;
        end
      end
      PH_WR_HI: begin
        scl = 1'b1; sda = shift_d[7]; drive = 1'b1;
      end
      PH_ACK_HI, PH_ACK_POLL, PH_RD_HI: begin
        scl = 1'b1; sda = 1'b1; drive = 1'b0;
      end
      PH_MA_LO: begin
        scl = 1'b0; sda = ~choice_d; drive = 1'b1;
      end
      default: begin
        scl = 1'b1; sda = ~choice_d; drive = 1'b1;
      end
    endcase

    if (phase_d == PH_ACK_POLL) begin
      if (!cmd_i.sda_in) begin
        phase_d = PH_HELD;
        done    = 1'b1;
      end else if (wait_d == cfg_i.ack_timeout_ticks) begin
        fail_d  = 1'b1;
        phase_d = PH_STO_A;
        timer_d = t_dbl;
      end else begin
        wait_d = wait_d + 8'd1;
      end
    end else if (!idle) begin
      if (timer_d != '0) begin
        timer_d = timer_d - TIMER_WIDTH'(1);
      end else begin
        unique case (phase_d)
          PH_RST: begin
            phase_d = PH_FREE;
            done    = 1'b1;
          end
          PH_STA_A: begin
            phase_d = PH_STA_B;
            timer_d = t_dbl;
          end
          PH_STA_B: begin
            phase_d = PH_HELD;
            done    = 1'b1;
          end
          PH_STO_A: begin
            phase_d = PH_STO_B;
            timer_d = t_half;
          end
          PH_STO_B: begin
            phase_d = PH_STO_C;
            timer_d = t_dbl;
          end
          PH_STO_C: begin
            phase_d = PH_FREE;
            done    = 1'b1;
          end
          PH_WR_LO: begin
            phase_d = (bit_d >= BYTE_BITS) ? PH_ACK_HI : PH_WR_HI;
            timer_d = t_half;
          end
          PH_WR_HI: begin
            shift_d = {shift_d[6:0], 1'b0};
            bit_d   = bit_d + 4'd1;
            phase_d = PH_WR_LO;
            timer_d = t_half;
          end
          PH_ACK_HI: begin
            wait_d  = '0;
            phase_d = PH_ACK_POLL;
            timer_d = '0;
          end
          PH_RD_LO: begin
            phase_d = (bit_d >= BYTE_BITS) ? PH_MA_LO : PH_RD_HI;
            timer_d = t_half;
          end
          PH_RD_HI: begin
            shift_d = {shift_d[6:0], cmd_i.sda_in};
            bit_d   = bit_d + 4'd1;
            if (bit_d >= BYTE_BITS) begin
              rx_d = shift_d;
            end
            phase_d = PH_RD_LO;
            timer_d = t_half;
          end
          PH_MA_LO: begin
            phase_d = PH_MA_HI;
            timer_d = t_half;
          end
          PH_MA_HI: begin
            phase_d = PH_HELD;
            done    = 1'b1;
          end
          default: begin
            phase_d = phase_d;
          end
        endcase
      end
    end

    res_o.scl_level        = scl;
    res_o.sda_level        = sda;
    res_o.sda_drive_enable = drive;
    res_o.busy_res         = ~idle;
    res_o.done_res         = done;
    res_o.rx_byte          = rx_d;
    res_o.ack_error        = fail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FREE;
      bit_q    <= '0;
      shift_q  <= '0;
      timer_q  <= '0;
      wait_q   <= '0;
      fail_q   <= 1'b0;
      choice_q <= 1'b0;
      rx_q     <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
      timer_q  <= timer_d;
      wait_q   <= wait_d;
      fail_q   <= fail_d;
      choice_q <= choice_d;
      rx_q     <= rx_d;
    end
  end

endmodule

@@ src/i2cm_out_reg.sv @@
module i2cm_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  i2cm_pkg::res_t data_i,
  output logic           ready_o,
  i2cm_res_if.source     res_o
);
  import i2cm_pkg::*;

  logic valid_q;
  res_t data_q;

  assign ready_o     = ~valid_q | res_o.ready;
  assign res_o.valid = valid_q;
  assign res_o.data  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import i2cm_pkg::*;

  localparam int unsigned TIMER_W = 16;
  localparam longint unsigned TMR_MAX = (64'd1 << TIMER_W) - 1;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned LONG_HOLD = 300;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  i2cm_cmd_if cmd_if ();
  i2cm_res_if res_if ();

  i2c_bit_level_master #(
    .TIMER_WIDTH(TIMER_W)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata)
  );

  // Engine state and register copies used to predict the pin levels.
  phase_e      ph;
  logic [3:0]  bit_idx;
  logic [7:0]  shreg;
  logic [15:0] tmr;
  logic [7:0]  ack_cnt;
  logic        ack_fail;
  logic        ack_pick;
  logic [7:0]  rx_last;
  logic [15:0] cfg_half;
  logic [7:0]  cfg_ack_to;
  logic [15:0] cfg_rst_hold;

  res_t        pin_res_q[$];
  int unsigned n_fail;
  int unsigned n_items;
  bit          idle_en;
  bit          long_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("i2c_bit_level_master test failed");
    $finish;
  end

  function automatic longint unsigned half_len();
    return (cfg_half == 0) ? 1 : cfg_half;
  endfunction

  function automatic void start_segment(phase_e p, longint unsigned len);
    if (len == 0) len = 1;
    ph = p;
    tmr = (len - 1 > TMR_MAX) ? TMR_MAX[15:0] : 16'(len - 1);
  endfunction

  function automatic void load_command(cmd_t c);
    case (c.action)
      ACT_BUS_RESET: start_segment(PH_RST, (cfg_rst_hold == 0) ? 1 : cfg_rst_hold);
      ACT_START:     start_segment(PH_STA_A, 2 * half_len());
      ACT_STOP:      start_segment(PH_STO_A, 2 * half_len());
      ACT_WRITE: begin
        shreg = c.tx_byte;
        bit_idx = '0;
        ack_fail = 1'b0;
        start_segment(PH_WR_LO, half_len());
      end
      ACT_READ: begin
        shreg = '0;
        bit_idx = '0;
        ack_pick = c.send_ack;
        start_segment(PH_RD_LO, half_len());
      end
      default: ;
    endcase
  endfunction

  function automatic logic close_segment(logic sda);
    longint unsigned h;
    h = half_len();
    case (ph)
      PH_RST: begin
        ph = PH_FREE;
        return 1'b1;
      end
      PH_STA_A: start_segment(PH_STA_B, 2 * h);
      PH_STA_B: begin
        ph = PH_HELD;
        return 1'b1;
      end
      PH_STO_A: start_segment(PH_STO_B, h);
      PH_STO_B: start_segment(PH_STO_C, 2 * h);
      PH_STO_C: begin
        ph = PH_FREE;
        return 1'b1;
      end
      PH_WR_LO: start_segment((bit_idx >= BYTE_BITS) ? PH_ACK_HI : PH_WR_HI, h);
      PH_WR_HI: begin
        shreg = shreg << 1;
        bit_idx = bit_idx + 4'd1;
        start_segment(PH_WR_LO, h);
      end
      PH_ACK_HI: begin
        ack_cnt = '0;
        ph = PH_ACK_POLL;
        tmr = '0;
      end
      PH_RD_LO: start_segment((bit_idx >= BYTE_BITS) ? PH_MA_LO : PH_RD_HI, h);
      PH_RD_HI: begin
        shreg = {shreg[6:0], sda};
        bit_idx = bit_idx + 4'd1;
        if (bit_idx >= BYTE_BITS) rx_last = shreg;
        start_segment(PH_RD_LO, h);
      end
      PH_MA_LO: start_segment(PH_MA_HI, h);
      PH_MA_HI: begin
        ph = PH_HELD;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic res_t engine_tick(cmd_t c);
    res_t r;
    logic idle;
    logic done;
    idle = (ph == PH_FREE) || (ph == PH_HELD);
    done = 1'b0;
    if (idle && c.cmd_valid && (c.action <= ACT_READ)) begin
      load_command(c);
      idle = 1'b0;
    end
    r.busy_res = ~idle;
    r.scl_level = 1'b1;
    r.sda_level = 1'b1;
    r.sda_drive_enable = 1'b1;
    case (ph)
      PH_HELD, PH_RD_LO: begin
        r.scl_level = 1'b0;
        r.sda_drive_enable = 1'b0;
      end
      PH_RST, PH_STO_A: begin
        r.scl_level = 1'b0;
        r.sda_level = 1'b0;
      end
      PH_STA_B, PH_STO_B: r.sda_level = 1'b0;
      PH_WR_LO: begin
        r.scl_level = 1'b0;
        if (bit_idx >= BYTE_BITS) r.sda_drive_enable = 1'b0;
        else r.sda_level = shreg[7];
      end
      PH_WR_HI: r.sda_level = shreg[7];
      PH_ACK_HI, PH_ACK_POLL, PH_RD_HI: r.sda_drive_enable = 1'b0;
      PH_MA_LO: begin
        r.scl_level = 1'b0;
        r.sda_level = ~ack_pick;
      end
      PH_MA_HI: r.sda_level = ~ack_pick;
      default: ;
    endcase
    if (ph == PH_ACK_POLL) begin
      if (!c.sda_in) begin
        ph = PH_HELD;
        done = 1'b1;
      end else if (ack_cnt == cfg_ack_to) begin
        ack_fail = 1'b1;
        start_segment(PH_STO_A, 2 * half_len());
      end else begin
        ack_cnt = ack_cnt + 8'd1;
      end
    end else if (!idle) begin
      if (tmr != 0) tmr = tmr - 16'd1;
      else done = close_segment(c.sda_in);
    end
    r.done_res = done;
    r.rx_byte = rx_last;
    r.ack_error = ack_fail;
    return r;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.cmd_valid = 1'($urandom_range(0, 1));
    c.action = 3'($urandom_range(0, 7));
    c.tx_byte = 8'($urandom);
    c.send_ack = 1'($urandom_range(0, 1));
    c.sda_in = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      n_fail++;
    end
  endtask

  task automatic check_pins(res_t act);
    res_t exp_r;
    if (pin_res_q.size() == 0) begin
      $display("%0t: unexpected result item: expected none, actual %0h", $time, act);
      n_fail++;
    end else begin
      exp_r = pin_res_q.pop_front();
      check_field("scl_level", exp_r.scl_level, act.scl_level);
      check_field("sda_level", exp_r.sda_level, act.sda_level);
      check_field("sda_drive_enable", exp_r.sda_drive_enable, act.sda_drive_enable);
      check_field("busy_res", exp_r.busy_res, act.busy_res);
      check_field("done_res", exp_r.done_res, act.done_res);
      check_field("rx_byte", exp_r.rx_byte, act.rx_byte);
      check_field("ack_error", exp_r.ack_error, act.ack_error);
    end
  endtask

  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        stall = idle_en ? $urandom_range(0, 10) : 0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      check_pins(res_if.data);
    end
  end

  task automatic send_tick(cmd_t c);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data <= c;
    do @(posedge clk_i); while (!cmd_if.ready);
    pin_res_q.push_back(engine_tick(c));
    n_items++;
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pin_res_q.size() != 0);
  endtask

  task automatic write_cfg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (addr)
      CFG_HALF_BIT:    cfg_half = data;
      CFG_ACK_TIMEOUT: cfg_ack_to = data[7:0];
      CFG_RESET_HOLD:  cfg_rst_hold = data;
      default: ;
    endcase
  endtask

  task automatic idle_ticks(int unsigned n);
    cmd_t c;
    repeat (n) begin
      c = rand_cmd();
      c.cmd_valid = 1'b0;
      send_tick(c);
    end
  endtask

  // A negative ack_after leaves SDA high for the whole acknowledge wait.
  task automatic run_cmd(logic [2:0] act, logic [7:0] tx, logic ack, int ack_after);
    cmd_t c;
    int polls;
    c = rand_cmd();
    c.cmd_valid = 1'b1;
    c.action = act;
    c.tx_byte = tx;
    c.send_ack = ack;
    polls = 0;
    send_tick(c);
    while (!(ph == PH_FREE || ph == PH_HELD)) begin
      c = rand_cmd();
      c.cmd_valid = ($urandom_range(0, 3) == 0);
      if (ph == PH_ACK_POLL) begin
        c.sda_in = (ack_after >= 0 && polls >= ack_after) ? 1'b0 : 1'b1;
        polls++;
      end
      send_tick(c);
    end
  endtask

  task automatic random_transfer();
    int unsigned n_bytes;
    n_bytes = $urandom_range(1, 3);
    run_cmd(ACT_START, 8'($urandom), 1'b0, 0);
    repeat (n_bytes) begin
      if ($urandom_range(0, 1) == 1) begin
        run_cmd(ACT_WRITE, 8'($urandom), 1'b0,
                ($urandom_range(0, 4) == 0) ? -1 : int'($urandom_range(0, cfg_ack_to + 1)));
      end else begin
        run_cmd(ACT_READ, 8'($urandom), 1'($urandom_range(0, 1)), 0);
      end
    end
    run_cmd(ACT_STOP, 8'($urandom), 1'b0, 0);
  endtask

  task automatic test_reset_values();
    idle_ticks(3);
    run_cmd(ACT_BUS_RESET, 8'h00, 1'b0, 0);
    run_cmd(ACT_START, 8'h00, 1'b0, 0);
    run_cmd(ACT_WRITE, 8'hA5, 1'b0, 0);
    run_cmd(ACT_WRITE, 8'hFF, 1'b0, 5);
    run_cmd(ACT_WRITE, 8'h00, 1'b0, -1);
    run_cmd(ACT_START, 8'h00, 1'b0, 0);
    run_cmd(ACT_READ, 8'h00, 1'b1, 0);
    run_cmd(ACT_READ, 8'h00, 1'b0, 0);
    run_cmd(3'd5, 8'h00, 1'b0, 0);
    run_cmd(3'd7, 8'hFF, 1'b1, 0);
    run_cmd(ACT_STOP, 8'h00, 1'b0, 0);
    run_cmd(ACT_WRITE, 8'h80, 1'b0, 1);
    run_cmd(ACT_STOP, 8'h00, 1'b0, 0);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    write_cfg(CFG_HALF_BIT, 16'd1);
    write_cfg(CFG_ACK_TIMEOUT, 16'd0);
    write_cfg(CFG_RESET_HOLD, 16'd1);
    run_cmd(ACT_BUS_RESET, 8'h00, 1'b0, 0);
    run_cmd(ACT_START, 8'h00, 1'b0, 0);
    run_cmd(ACT_WRITE, 8'h3C, 1'b0, -1);
    run_cmd(ACT_START, 8'h00, 1'b0, 0);
    run_cmd(ACT_WRITE, 8'hC3, 1'b0, 0);
    run_cmd(ACT_READ, 8'h00, 1'b1, 0);
    run_cmd(ACT_STOP, 8'h00, 1'b0, 0);
    write_cfg(CFG_HALF_BIT, 16'd0);
    write_cfg(CFG_RESET_HOLD, 16'd0);
    run_cmd(ACT_BUS_RESET, 8'h00, 1'b0, 0);
    run_cmd(ACT_START, 8'h00, 1'b0, 0);
    run_cmd(ACT_READ, 8'h00, 1'b0, 0);
    run_cmd(ACT_STOP, 8'h00, 1'b0, 0);
    write_cfg(CFG_HALF_BIT, 16'd2);
    write_cfg(CFG_ACK_TIMEOUT, 16'd255);
    run_cmd(ACT_START, 8'h00, 1'b0, 0);
    run_cmd(ACT_WRITE, 8'h01, 1'b0, -1);
    run_cmd(ACT_STOP, 8'h00, 1'b0, 0);
    wait_drained();
  endtask

  task automatic test_long_segments();
    idle_en = 1'b0;
    write_cfg(CFG_HALF_BIT, 16'd24);
    run_cmd(ACT_START, 8'h00, 1'b0, 0);
    write_cfg(CFG_HALF_BIT, 16'd1);
    run_cmd(ACT_STOP, 8'h00, 1'b0, 0);
    write_cfg(CFG_RESET_HOLD, 16'd90);
    run_cmd(ACT_BUS_RESET, 8'h00, 1'b0, 0);
    write_cfg(CFG_RESET_HOLD, 16'd3);
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    write_cfg(CFG_HALF_BIT, 16'd1);
    write_cfg(CFG_ACK_TIMEOUT, 16'd4);
    idle_en = 1'b0;
    long_hold_req = 1'b1;
    random_transfer();
    random_transfer();
    idle_en = 1'b1;
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned stop_at;
    repeat (4) begin
      write_cfg(CFG_HALF_BIT, 16'($urandom_range(1, 3)));
      write_cfg(CFG_ACK_TIMEOUT, 16'($urandom_range(0, 8)));
      write_cfg(CFG_RESET_HOLD, 16'($urandom_range(1, 6)));
      stop_at = n_items + 20;
      while (n_items < stop_at) begin
        if ($urandom_range(0, 3) != 0) begin
          random_transfer();
        end else begin
          run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                  ($urandom_range(0, 2) == 0) ? -1 : int'($urandom_range(0, 3)));
        end
        idle_ticks($urandom_range(0, 2));
      end
      wait_drained();
    end
  endtask

  initial begin
    ph = PH_FREE;
    bit_idx = '0;
    shreg = '0;
    tmr = '0;
    ack_cnt = '0;
    ack_fail = 1'b0;
    ack_pick = 1'b0;
    rx_last = '0;
    cfg_half = HALF_BIT_RST;
    cfg_ack_to = ACK_TIMEOUT_RST;
    cfg_rst_hold = RESET_HOLD_RST;
    n_fail = 0;
    n_items = 0;
    idle_en = 1'b1;
    long_hold_req = 1'b0;
    rst_ni <= 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.data <= '0;
    res_if.ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_config_extremes();
    test_long_segments();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("i2c_bit_level_master test passed");
    end else begin
      $display("i2c_bit_level_master test failed");
    end
    $finish;
  end

endmodule
